### rtl/core/sssd_pkg.sv
// ----------------------------------------------------------------------------
// sssd_pkg
// Shared constants, types and helpers for the seven-segment scan driver.
// ----------------------------------------------------------------------------
package sssd_pkg;

   localparam int DIGITS_DEFAULT = 3;
   localparam int MAX_DIGITS     = 3;
   localparam int SEG_W          = 7;
   localparam int SLOT_W         = 2;

   localparam logic FUNC_SET  = 1'b0;
   localparam logic FUNC_SCAN = 1'b1;

   typedef struct packed {
      logic [MAX_DIGITS-1:0]            wr_en;
      logic [MAX_DIGITS-1:0][SEG_W-1:0] pattern;
   } split_type;

   function automatic logic [SEG_W-1:0] seg_pattern(input logic [3:0] digit);
      logic [SEG_W-1:0] pat;
      unique case (digit)
         4'd0:    pat = 7'h77;
         4'd1:    pat = 7'h24;
         4'd2:    pat = 7'h5D;
         4'd3:    pat = 7'h6D;
         4'd4:    pat = 7'h2E;
         4'd5:    pat = 7'h6B;
         4'd6:    pat = 7'h7B;
         4'd7:    pat = 7'h25;
         4'd8:    pat = 7'h7F;
         4'd9:    pat = 7'h6F;
         default: pat = '0;
      endcase
      return pat;
   endfunction

   // exact for every 8-bit value
   function automatic logic [7:0] div10(input logic [7:0] x);
      logic [18:0] prod;
      prod = {11'd0, x} * 19'd205;
      return prod[18:11];
   endfunction

endpackage

### rtl/core/sssd_split.sv
// ----------------------------------------------------------------------------
// sssd_split
// Split a byte into decimal digits, most significant first, and look up
// each digit's segment pattern with its store write enable.
// ----------------------------------------------------------------------------
module sssd_split #(
   parameter int DIGITS = sssd_pkg::DIGITS_DEFAULT
) (
   input  logic [7:0]          value,
   output sssd_pkg::split_type split
);

   logic [7:0] hund;
   logic [7:0] rem100;
   logic [7:0] tens_src;
   logic [7:0] q10;
   logic [7:0] ones;
   logic [sssd_pkg::MAX_DIGITS-1:0][7:0] digit;

   always_comb begin
      if (value >= 8'd200) begin
         hund   = 8'd2;
         rem100 = value - 8'd200;
      end else if (value >= 8'd100) begin
         hund   = 8'd1;
         rem100 = value - 8'd100;
      end else begin
         hund   = 8'd0;
         rem100 = value;
      end
      tens_src = (DIGITS >= 3) ? rem100 : value;
      q10      = sssd_pkg::div10(tens_src);
      ones     = tens_src - 8'((q10 << 3) + (q10 << 1));

      digit = '0;
      if (DIGITS >= 3) begin
         digit[0] = hund;
         digit[1] = q10;
         digit[2] = ones;
      end else if (DIGITS == 2) begin
         digit[0] = q10;
         digit[1] = ones;
      end else begin
         digit[0] = value;
      end

      for (int i = 0; i < sssd_pkg::MAX_DIGITS; i++) begin
         split.wr_en[i]   = (i < DIGITS) && (digit[i] < 8'd10);
         split.pattern[i] = sssd_pkg::seg_pattern(digit[i][3:0]);
      end
   end

endmodule

### rtl/core/seven_segment_scan_driver.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_driver
// Multiplexed seven-segment driver: set requests store digit patterns, scan
// requests return the drive for the current slot and advance the slot.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | direction
//  req      | req_valid req_ready req_func req_value  | in
//  rsp      | rsp_valid rsp_ready rsp_common_drive    | out
//           | rsp_segment_drive                       |
//
//  One request per cycle while req_ready is high; a scan result appears in the
//  cycle after acceptance from the result register. Set requests give no
//  result. Reset clears the digit store, slot index and result valid flag.
//  A request is taken whenever the result register is empty or being read,
//  so rsp_ready low stalls the input only while a result waits.
// ----------------------------------------------------------------------------
module seven_segment_scan_driver #(
   parameter int DIGITS = sssd_pkg::DIGITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_func,
   input  logic [7:0]                req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [2:0]                rsp_common_drive,
   output logic [sssd_pkg::SEG_W-1:0] rsp_segment_drive
);

   sssd_pkg::split_type split;

   logic [DIGITS-1:0][sssd_pkg::SEG_W-1:0] patterns_ff, patterns_in;
   logic [sssd_pkg::SLOT_W-1:0]            slot_ff, slot_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [2:0]                             common_ff, common_in;
   logic [sssd_pkg::SEG_W-1:0]             segment_ff, segment_in;
   logic                                   accept;

   sssd_split #(.DIGITS(DIGITS)) u_split (
      .value (req_value),
      .split (split)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      patterns_in  = patterns_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      common_in    = common_ff;
      segment_in   = segment_ff;
      if (accept) begin
         if (req_func == sssd_pkg::FUNC_SET) begin
            for (int i = 0; i < DIGITS; i++) begin
               if (split.wr_en[i]) begin
                  patterns_in[i] = split.pattern[i];
               end
            end
         end else begin
            common_in  = '0;
            segment_in = '0;
            for (int i = 0; i < DIGITS; i++) begin
               if (slot_ff == sssd_pkg::SLOT_W'(i)) begin
                  common_in  = 3'(1 << i);
                  segment_in = patterns_ff[i];
               end
            end
            slot_in      = slot_ff + 1'b1;
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         patterns_ff  <= '0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         patterns_ff  <= patterns_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      common_ff  <= common_in;
      segment_ff <= segment_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_common_drive  = common_ff;
   assign rsp_segment_drive = segment_ff;

endmodule
